// File: rtl/window_zorder_hit_test_unit_defines.svh
// Assertion macros shared by the window hit-test block.
`ifndef WINDOW_ZORDER_HIT_TEST_UNIT_DEFINES_SVH
`define WINDOW_ZORDER_HIT_TEST_UNIT_DEFINES_SVH

// Implication checked on every clock edge outside reset.
`define WZH_ASSERT_IMPL(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication checked outside reset.
`define WZH_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: rtl/wzh_pkg.sv
`default_nettype none
package wzh_pkg;
   localparam int Slots = 16;
   localparam int SlotW = 4;
   localparam logic [4:0] NoSlot = 5'd16;

   localparam logic [1:0] ModeSet = 2'd0;
   localparam logic [1:0] ModePress = 2'd1;
   localparam logic [1:0] ModeHold = 2'd2;
   localparam logic [1:0] ModeRelease = 2'd3;

   localparam logic [2:0] EvNone = 3'd0;
   localparam logic [2:0] EvDrag = 3'd1;
   localparam logic [2:0] EvClose = 3'd2;
   localparam logic [2:0] EvClick = 3'd3;
   localparam logic [2:0] EvMove = 3'd4;
   localparam logic [2:0] EvWrite = 3'd5;

   localparam logic [2:0] RegTitle = 3'd0;
   localparam logic [2:0] RegCloseTop = 3'd1;
   localparam logic [2:0] RegCloseBot = 3'd2;
   localparam logic [2:0] RegCloseFar = 3'd3;
   localparam logic [2:0] RegCloseNear = 3'd4;

   typedef struct packed {
      logic [1:0]  mode;
      logic [3:0]  slot;
      logic signed [12:0] pos_x;
      logic signed [12:0] pos_y;
      logic [11:0] win_width;
      logic [11:0] win_height;
      logic        win_active;
   } req_type;

   typedef struct packed {
      logic [2:0]  event_kind;
      logic [3:0]  event_slot;
      logic [4:0]  focus_now;
      logic        focus_changed;
      logic signed [13:0] local_x;
      logic signed [13:0] local_y;
      logic signed [12:0] moved_x;
      logic signed [12:0] moved_y;
   } rsp_type;

   // Controller to datapath.
   typedef struct packed {
      logic load;      // capture request, begin item
      logic scan_step; // test one stack entry
      logic raise_step;// shift one stack entry
      logic finish;    // commit the result
   } cmd_type;

   // Datapath to controller.
   typedef struct packed {
      logic is_press;  // item needs a stack walk
      logic scan_done; // walk ended (hit or exhausted)
      logic need_raise;// hit window must go to the top
      logic raise_done;
   } sts_type;
endpackage
`default_nettype wire

// File: rtl/window_zorder_hit_test_unit.sv
`default_nettype none
// A write, hold or release goes from the accepted beat through the scan state, where it
// does not walk, and the done state to the result; a press with no drag under way walks
// the stack from the top until a hit or the bottom and, when focus moves, shifts the stack.
// Only one beat is in flight; the next beat is accepted in the cycle after the result
// is committed, and a stalled response holds the block in its done state.
// Reset (synchronous, active high) empties the window table, restores the default
// stacking order and button geometry, and clears focus and drag.
`include "window_zorder_hit_test_unit_defines.svh"
module window_zorder_hit_test_unit
   import wzh_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   // mode[1:0], slot[5:2], pos_x[18:6], pos_y[31:19], win_width[43:32],
   // win_height[55:44], win_active[56], zero fill to 64 bits
   input  wire logic [63:0] req_tdata,
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   // event_kind[2:0], event_slot[6:3], focus_now[11:7], focus_changed[12],
   // local_x[26:13], local_y[40:27], moved_x[53:41], moved_y[66:54], zero fill to 72
   output logic [71:0]      rsp_tdata,
   input  wire logic        csr_we,
   input  wire logic [2:0]  csr_index,
   input  wire logic [7:0]  csr_wdata
);
   cmd_type cmd;
   sts_type sts;
   rsp_type result;
   req_type req;
   logic busy, req_fire, out_free, rsp_valid_ff;

   // Unpack the request beat field by field; the first field sits in the lowest bits.
   assign req.mode = req_tdata[1:0];
   assign req.slot = req_tdata[5:2];
   assign req.pos_x = req_tdata[18:6];
   assign req.pos_y = req_tdata[31:19];
   assign req.win_width = req_tdata[43:32];
   assign req.win_height = req_tdata[55:44];
   assign req.win_active = req_tdata[56];
   assign req_tready = !busy;
   assign req_fire = req_tvalid && req_tready;
   // The result register may be refilled once the old beat has gone or goes now.
   assign out_free = !rsp_valid_ff || rsp_tready;

   wzh_ctrl u_ctrl (
      .clock(clock), .reset(reset), .req_fire(req_fire), .out_free(out_free),
      .sts(sts), .cmd(cmd), .busy(busy)
   );

   wzh_datapath u_dp (
      .clock(clock), .reset(reset), .cmd(cmd), .req(req), .csr_we(csr_we),
      .csr_index(csr_index), .csr_wdata(csr_wdata), .sts(sts), .result(result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.finish) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata = {5'b0, result.moved_y, result.moved_x, result.local_y,
                       result.local_x, result.focus_changed, result.focus_now,
                       result.event_slot, result.event_kind};

   // A result is only committed when the output register can take it.
   `WZH_ASSERT_IMPL(a_no_overrun, cmd.finish, out_free, "result overwritten")
   // Only one item is in flight: no input beat while busy.
   `WZH_ASSERT_IMPL(a_one_item, busy, !req_tready, "beat accepted while busy")
   // A committed result shows up as a valid beat next cycle.
   `WZH_ASSERT_NEXT(a_rsp_follows, cmd.finish, rsp_tvalid, "result lost")
endmodule
`default_nettype wire

// File: rtl/wzh_ctrl.sv
`default_nettype none
module wzh_ctrl
   import wzh_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_fire,
   input  wire logic    out_free,
   input  wire sts_type sts,
   output cmd_type      cmd,
   output logic         busy
);
   typedef enum logic [3:0] {
      StIdle  = 4'b0001,
      StScan  = 4'b0010,
      StRaise = 4'b0100,
      StDone  = 4'b1000
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      cmd = '0;
      unique case (state_ff)
         StIdle: begin
            if (req_fire) begin
               cmd.load = 1'b1;
               state_in = StScan;
            end
         end
         StScan: begin
            if (!sts.is_press || sts.scan_done) begin
               state_in = sts.need_raise ? StRaise : StDone;
            end else begin
               cmd.scan_step = 1'b1;
            end
         end
         StRaise: begin
            if (sts.raise_done) begin
               state_in = StDone;
            end else begin
               cmd.raise_step = 1'b1;
            end
         end
         StDone: begin
            if (out_free) begin
               cmd.finish = 1'b1;
               state_in = StIdle;
            end
         end
         default: state_in = StIdle;
      endcase
   end

   assign busy = (state_ff != StIdle);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= StIdle;
      end else begin
         state_ff <= state_in;
      end
   end
endmodule
`default_nettype wire

// File: rtl/wzh_datapath.sv
`default_nettype none
module wzh_datapath
   import wzh_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire cmd_type    cmd,
   input  wire req_type    req,
   input  wire logic       csr_we,
   input  wire logic [2:0] csr_index,
   input  wire logic [7:0] csr_wdata,
   output sts_type         sts,
   output rsp_type         result
);
   logic signed [12:0] org_x_ff [Slots];
   logic signed [12:0] org_y_ff [Slots];
   logic [11:0] w_ff [Slots];
   logic [11:0] h_ff [Slots];
   logic [Slots-1:0] on_ff;
   logic [SlotW-1:0] stack_ff [Slots];
   logic [4:0] focus_ff, drag_ff;
   logic signed [13:0] off_x_ff, off_y_ff;
   logic [7:0] title_ff, ctop_ff, cbot_ff, cfar_ff, cnear_ff;

   req_type r_ff;
   logic [SlotW-1:0] ptr_ff;      // scan index, then raise index
   logic scan_done_ff, hit_ff;
   logic [SlotW-1:0] hit_slot_ff;
   logic signed [13:0] lx_ff, ly_ff;

   // One stack entry under test.
   logic [SlotW-1:0] cur_s;
   logic signed [14:0] px, py, ox, oy, rx, ry;
   logic inside_hit;
   assign cur_s = stack_ff[ptr_ff];
   assign px = 15'(r_ff.pos_x);
   assign py = 15'(r_ff.pos_y);
   assign ox = 15'(org_x_ff[cur_s]);
   assign oy = 15'(org_y_ff[cur_s]);
   assign rx = ox + 15'({3'b0, w_ff[cur_s]});
   assign ry = oy + 15'({3'b0, h_ff[cur_s]});
   assign inside_hit = on_ff[cur_s] && px >= ox && px <= rx && py >= oy && py <= ry;

   assign sts.is_press = (r_ff.mode == ModePress) && (drag_ff == NoSlot);
   assign sts.scan_done = scan_done_ff;
   assign sts.need_raise = hit_ff && (focus_ff != {1'b0, hit_slot_ff});
   assign sts.raise_done = (ptr_ff == SlotW'(Slots - 1));

   // Press classification of the hit window.
   logic signed [13:0] hw;
   logic in_close, in_title;
   assign hw = 14'({2'b0, w_ff[hit_slot_ff]});
   assign in_close = ly_ff >= $signed({6'b0, ctop_ff}) && ly_ff <= $signed({6'b0, cbot_ff})
                  && lx_ff >= hw - $signed({6'b0, cfar_ff})
                  && lx_ff <= hw - $signed({6'b0, cnear_ff});
   assign in_title = ly_ff <= $signed({6'b0, title_ff});

   // Hold arithmetic; drag moves are saturated to 13 bits.
   logic signed [14:0] mvx, mvy;
   logic signed [12:0] satx, saty;
   logic [SlotW-1:0] dslot, fslot;
   logic signed [14:0] hlx, hly;
   assign dslot = drag_ff[SlotW-1:0];
   assign fslot = focus_ff[SlotW-1:0];
   assign mvx = px - 15'(off_x_ff);
   assign mvy = py - 15'(off_y_ff);
   assign satx = (mvx > 15'sd4095) ? 13'sd4095 : (mvx < -15'sd4096) ? -13'sd4096 : mvx[12:0];
   assign saty = (mvy > 15'sd4095) ? 13'sd4095 : (mvy < -15'sd4096) ? -13'sd4096 : mvy[12:0];
   assign hlx = px - 15'(org_x_ff[fslot]);
   assign hly = py - 15'(org_y_ff[fslot]);

   always_ff @(posedge clock) begin
      if (reset) begin
         on_ff <= '0;
         focus_ff <= NoSlot;
         drag_ff <= NoSlot;
         off_x_ff <= '0;
         off_y_ff <= '0;
         title_ff <= 8'd25;
         ctop_ff <= 8'd6;
         cbot_ff <= 8'd22;
         cfar_ff <= 8'd22;
         cnear_ff <= 8'd6;
         for (int i = 0; i < Slots; i++) begin
            stack_ff[i] <= SlotW'(i);
            org_x_ff[i] <= '0;
            org_y_ff[i] <= '0;
            w_ff[i] <= '0;
            h_ff[i] <= '0;
         end
         scan_done_ff <= 1'b0;
         hit_ff <= 1'b0;
      end else begin
         if (csr_we) begin
            unique case (csr_index)
               RegTitle: title_ff <= csr_wdata;
               RegCloseTop: ctop_ff <= csr_wdata;
               RegCloseBot: cbot_ff <= csr_wdata;
               RegCloseFar: cfar_ff <= csr_wdata;
               RegCloseNear: cnear_ff <= csr_wdata;
               default: ;
            endcase
         end
         if (cmd.load) begin
            r_ff <= req;
            ptr_ff <= SlotW'(Slots - 1);
            scan_done_ff <= 1'b0;
            hit_ff <= 1'b0;
         end
         if (cmd.scan_step) begin
            if (inside_hit) begin
               hit_ff <= 1'b1;
               scan_done_ff <= 1'b1;
               hit_slot_ff <= cur_s;
               lx_ff <= 14'(px - ox);
               ly_ff <= 14'(py - oy);
            end else if (ptr_ff == '0) begin
               scan_done_ff <= 1'b1;
            end else begin
               ptr_ff <= ptr_ff - 1'b1;
            end
         end
         if (cmd.raise_step) begin
            // Entries from the hit position up shift down by one.
            stack_ff[ptr_ff] <= stack_ff[ptr_ff + 1'b1];
            ptr_ff <= ptr_ff + 1'b1;
         end
         if (cmd.finish) begin
            result <= '0;
            result.focus_now <= focus_ff;
            unique case (r_ff.mode)
               ModeSet: begin
                  org_x_ff[r_ff.slot] <= r_ff.pos_x;
                  org_y_ff[r_ff.slot] <= r_ff.pos_y;
                  w_ff[r_ff.slot] <= r_ff.win_width;
                  h_ff[r_ff.slot] <= r_ff.win_height;
                  on_ff[r_ff.slot] <= r_ff.win_active;
                  result.event_kind <= EvWrite;
                  result.event_slot <= r_ff.slot;
                  if (!r_ff.win_active) begin
                     if (focus_ff == {1'b0, r_ff.slot}) begin
                        focus_ff <= NoSlot;
                        result.focus_now <= NoSlot;
                     end
                     if (drag_ff == {1'b0, r_ff.slot}) drag_ff <= NoSlot;
                  end
               end
               ModePress: begin
                  if (sts.is_press && hit_ff) begin
                     result.event_slot <= hit_slot_ff;
                     result.local_x <= lx_ff;
                     result.local_y <= ly_ff;
                     result.focus_changed <= sts.need_raise;
                     if (sts.need_raise) stack_ff[Slots-1] <= hit_slot_ff;
                     if (in_close) begin
                        on_ff[hit_slot_ff] <= 1'b0;
                        focus_ff <= NoSlot;
                        result.focus_now <= NoSlot;
                        result.event_kind <= EvClose;
                     end else begin
                        focus_ff <= {1'b0, hit_slot_ff};
                        result.focus_now <= {1'b0, hit_slot_ff};
                        if (in_title) begin
                           drag_ff <= {1'b0, hit_slot_ff};
                           off_x_ff <= lx_ff;
                           off_y_ff <= ly_ff;
                           result.event_kind <= EvDrag;
                        end else begin
                           result.event_kind <= EvClick;
                        end
                     end
                  end
               end
               ModeHold: begin
                  if (drag_ff != NoSlot) begin
                     org_x_ff[dslot] <= satx;
                     org_y_ff[dslot] <= saty;
                     result.event_kind <= EvMove;
                     result.event_slot <= dslot;
                     result.moved_x <= satx;
                     result.moved_y <= saty;
                  end else if (focus_ff != NoSlot && on_ff[fslot]) begin
                     result.event_kind <= EvClick;
                     result.event_slot <= fslot;
                     result.local_x <= hlx[13:0];
                     result.local_y <= hly[13:0];
                  end
               end
               ModeRelease: drag_ff <= NoSlot;
               default: ;
            endcase
         end
      end
   end
endmodule
`default_nettype wire
